[rtl/assert_macros.svh]
// Assertion macros shared by the escape decoder RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SED_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SED_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `SED_ASSERT(label, clk, rst_n, !(expr), msg)
`else
`define SED_ASSERT(label, clk, rst_n, prop, msg)
`define SED_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/sed_pkg.sv]
// Shared types and constants of the string escape decoder.
// No dependencies.
`default_nettype none

package sed_pkg;

    localparam int ZERO_MAX = 32;
    localparam int ZCW = $clog2(ZERO_MAX + 2);
    localparam int CNTW = (ZCW > 3) ? ZCW : 3;
    localparam logic [ZCW-1:0] ZERO_BOUND = ZCW'(ZERO_MAX);
    localparam logic [ZCW-1:0] ZERO_SAT = ZCW'(ZERO_MAX + 1);

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic [2:0] DIG_MAX_U = 3'd4;
    localparam logic [2:0] DIG_MAX_X = 3'd2;

    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [1:0] {
        KIND_OCT,
        KIND_X,
        KIND_U
    } t_kind;

    // One command: prefix, zeros, digits, value bytes, tail byte, empty result.
    typedef struct packed {
        logic            pre_en;
        logic            pre_err;
        t_kind           kind;
        logic            zov;
        logic [ZCW-1:0]  nzero;
        logic [2:0]      ndig;
        logic [3:0][7:0] dig;
        logic [1:0]      nval;
        logic [15:0]     val;
        logic            tail_en;
        logic [7:0]      tail;
        logic            tail_zov;
        logic            eos;
        logic            empty_res;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/sed_ifs.sv]
// Valid/ready channel interfaces for input bytes and decoded words.
// No dependencies.
`default_nettype none

interface sed_in_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_byte;
    logic       end_of_string;

    modport source (output valid, output has_char, output char_byte,
                    output end_of_string, input ready);
    modport sink (input valid, input has_char, input char_byte,
                  input end_of_string, output ready);
endinterface

interface sed_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       escape_error;
    logic       zero_overflow;
    logic       run_last;
    logic       string_done;

    modport source (output valid, output has_byte, output out_byte,
                    output escape_error, output zero_overflow,
                    output run_last, output string_done, input ready);
    modport sink (input valid, input has_byte, input out_byte,
                  input escape_error, input zero_overflow,
                  input run_last, input string_done, output ready);
endinterface

`default_nettype wire

[rtl/string_escape_decoder_unit.sv]
// Top level of the string escape decoder: front end, command queue, emitter.
// Depends on sed_pkg, sed_ifs, sed_front, sed_queue and sed_back.
//
//   channel  dir  modport            word
//   i_in     in   sed_in_if.sink     has_char, char_byte, end_of_string
//   o_out    out  sed_out_if.source  has_byte, out_byte, escape_error,
//                                    zero_overflow, run_last, string_done
//
// An input word is taken while the command queue has room.
// The emitter sends one output word per cycle while o_out is ready; an input word yields 0 to
// ZERO_MAX + 7 output words, so throughput is set by the emitter's output rate.
// A 4-entry command queue decouples intake from output stalls.
// Synchronous active-low reset returns to no pending escape and empties the queue.
`default_nettype none

module string_escape_decoder_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    sed_in_if.sink        i_in,
    sed_out_if.source     o_out
);

    logic             w_full, w_push, w_valid, w_pop;
    sed_pkg::t_cmd    w_cmd_in, w_cmd_out;

    sed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    sed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_cmd   (w_cmd_out),
        .i_pop   (w_pop)
    );

    sed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_cmd   (w_cmd_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[rtl/sed_front.sv]
// Front end: accepts body bytes, tracks escape state, issues emit commands.
// Depends on sed_pkg, sed_ifs and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sed_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sed_in_if.sink           i_in,
    input  wire              i_full,
    output logic             o_push,
    output sed_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BSL,
        MODE_DIGITS,
        MODE_PREFIX
    } t_mode;

    t_mode                     r_mode, n_mode;
    sed_pkg::t_kind            r_kind, n_kind;
    logic [sed_pkg::ZCW-1:0]   r_zero, n_zero;
    logic [2:0]                r_dcnt, n_dcnt;
    logic [15:0]               r_acc, n_acc;
    logic [3:0][7:0]           r_dstore, n_dstore;
    sed_pkg::t_cmd             w_cmd;
    logic                      w_accept;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, c[3:0]};
            [8'h41:8'h46], [8'h61:8'h66]: res = {1'b1, c[3:0] + 4'd9};
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [8:0] simple_map(input logic [7:0] c);
        logic [8:0] res;
        res = '0;
        unique case (c)
            8'h61: res = {1'b1, 8'h07};
            8'h62: res = {1'b1, 8'h08};
            8'h66: res = {1'b1, 8'h0c};
            8'h6e: res = {1'b1, 8'h0a};
            8'h72: res = {1'b1, 8'h0d};
            8'h74: res = {1'b1, 8'h09};
            8'h76: res = {1'b1, 8'h0b};
            8'h3f, 8'h22, 8'h27, 8'h5c: res = {1'b1, c};
            default: res = '0;
        endcase
        return res;
    endfunction

    assign i_in.ready = !i_full;
    assign w_accept = i_in.valid && i_in.ready;
    assign o_push = w_accept && (w_cmd.pre_en || (w_cmd.nval != 2'd0) || w_cmd.tail_en
                                 || w_cmd.eos);
    assign o_cmd = w_cmd;

    always_comb begin
        logic [7:0]  ch;
        logic [4:0]  hx;
        logic [8:0]  sm;
        logic        is_oct;
        logic        take;
        logic        rej;
        logic        zov;
        logic [10:0] oct_next;

        ch = i_in.char_byte;
        hx = hex_decode(ch);
        sm = simple_map(ch);
        is_oct = (ch[7:3] == 5'b00110);
        zov = (r_zero > sed_pkg::ZERO_BOUND);
        oct_next = {r_acc[7:0], 3'b000} + {7'd0, hx[3:0]};
        take = 1'b0;
        rej = 1'b0;

        n_mode = r_mode;
        n_kind = r_kind;
        n_zero = r_zero;
        n_dcnt = r_dcnt;
        n_acc = r_acc;
        n_dstore = r_dstore;
        w_cmd = '0;
        w_cmd.kind = sed_pkg::KIND_OCT;

        if (i_in.has_char) begin
            unique case (r_mode)
                MODE_BSL: begin
                    if (is_oct) begin
                        n_kind = sed_pkg::KIND_OCT;
                        n_mode = MODE_DIGITS;
                        take = 1'b1;
                    end else if (ch == sed_pkg::CH_X || ch == sed_pkg::CH_U) begin
                        n_kind = (ch == sed_pkg::CH_X) ? sed_pkg::KIND_X : sed_pkg::KIND_U;
                        n_mode = MODE_PREFIX;
                    end else if (sm[8]) begin
                        w_cmd.tail_en = 1'b1;
                        w_cmd.tail = sm[7:0];
                        n_mode = MODE_IDLE;
                        n_kind = sed_pkg::KIND_OCT;
                    end else begin
                        w_cmd.pre_en = 1'b1;
                        w_cmd.pre_err = 1'b1;
                        w_cmd.tail_en = 1'b1;
                        w_cmd.tail = ch;
                        n_mode = MODE_IDLE;
                        n_kind = sed_pkg::KIND_OCT;
                    end
                end
                MODE_PREFIX: begin
                    if (hx[4]) begin
                        n_mode = MODE_DIGITS;
                        take = 1'b1;
                    end else begin
                        w_cmd.pre_en = 1'b1;
                        w_cmd.kind = r_kind;
                        n_kind = sed_pkg::KIND_OCT;
                        if (ch == sed_pkg::CH_BSL) begin
                            n_mode = MODE_BSL;
                        end else begin
                            n_mode = MODE_IDLE;
                            w_cmd.tail_en = 1'b1;
                            w_cmd.tail = ch;
                        end
                    end
                end
                MODE_DIGITS: begin
                    if ((r_kind == sed_pkg::KIND_OCT) ? is_oct : hx[4]) begin
                        take = 1'b1;
                    end else begin
                        w_cmd.nval = (r_kind == sed_pkg::KIND_U) ? 2'd2 : 2'd1;
                        w_cmd.val = r_acc;
                        w_cmd.zov = zov;
                        n_kind = sed_pkg::KIND_OCT;
                        n_zero = '0;
                        n_dcnt = '0;
                        n_acc = '0;
                        if (ch == sed_pkg::CH_BSL) begin
                            n_mode = MODE_BSL;
                        end else begin
                            n_mode = MODE_IDLE;
                            w_cmd.tail_en = 1'b1;
                            w_cmd.tail = ch;
                        end
                    end
                end
                MODE_IDLE: begin
                    if (ch == sed_pkg::CH_BSL) begin
                        n_mode = MODE_BSL;
                    end else begin
                        w_cmd.tail_en = 1'b1;
                        w_cmd.tail = ch;
                    end
                end
            endcase
        end

        if (take) begin
            if (r_dcnt == 3'd0 && hx[3:0] == 4'd0) begin
                if (r_zero <= sed_pkg::ZERO_BOUND) begin
                    n_zero = r_zero + 1'b1;
                end
            end else begin
                if (n_kind == sed_pkg::KIND_OCT) begin
                    rej = |oct_next[10:8];
                end else if (n_kind == sed_pkg::KIND_X) begin
                    rej = (r_dcnt >= sed_pkg::DIG_MAX_X);
                end else begin
                    rej = (r_dcnt >= sed_pkg::DIG_MAX_U);
                end
                if (rej) begin
                    w_cmd.pre_en = 1'b1;
                    w_cmd.pre_err = 1'b1;
                    w_cmd.kind = n_kind;
                    w_cmd.zov = zov;
                    w_cmd.nzero = zov ? sed_pkg::ZERO_BOUND : r_zero;
                    w_cmd.ndig = r_dcnt;
                    w_cmd.dig = r_dstore;
                    w_cmd.tail_en = 1'b1;
                    w_cmd.tail = ch;
                    w_cmd.tail_zov = zov;
                    n_mode = MODE_IDLE;
                    n_kind = sed_pkg::KIND_OCT;
                    n_zero = '0;
                    n_dcnt = '0;
                    n_acc = '0;
                end else begin
                    n_dstore[r_dcnt[1:0]] = ch;
                    n_dcnt = r_dcnt + 3'd1;
                    n_acc = (n_kind == sed_pkg::KIND_OCT) ? {5'd0, oct_next}
                                                          : {r_acc[11:0], hx[3:0]};
                end
            end
        end

        if (i_in.end_of_string) begin
            unique case (n_mode)
                MODE_BSL: begin
                    w_cmd.tail_en = 1'b1;
                    w_cmd.tail = sed_pkg::CH_BSL;
                end
                MODE_PREFIX: begin
                    w_cmd.pre_en = 1'b1;
                    w_cmd.kind = n_kind;
                end
                MODE_DIGITS: begin
                    w_cmd.nval = (n_kind == sed_pkg::KIND_U) ? 2'd2 : 2'd1;
                    w_cmd.val = n_acc;
                    w_cmd.zov = (n_zero > sed_pkg::ZERO_BOUND);
                end
                MODE_IDLE: begin
                end
            endcase
            w_cmd.eos = 1'b1;
            w_cmd.empty_res = !(w_cmd.pre_en || (w_cmd.nval != 2'd0) || w_cmd.tail_en);
            n_mode = MODE_IDLE;
            n_kind = sed_pkg::KIND_OCT;
            n_zero = '0;
            n_dcnt = '0;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_kind <= sed_pkg::KIND_OCT;
            r_zero <= '0;
            r_dcnt <= '0;
            r_acc <= '0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_kind <= n_kind;
            r_zero <= n_zero;
            r_dcnt <= n_dcnt;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dstore <= n_dstore;
        end
    end

    `SED_ASSERT(a_zero_saturates, i_clk, i_rst_n, r_zero <= sed_pkg::ZERO_SAT, "zero count past saturation")
    `SED_ASSERT(a_digit_bound, i_clk, i_rst_n, r_dcnt <= sed_pkg::DIG_MAX_U, "too many stored digits")

endmodule

`default_nettype wire

[rtl/sed_queue.sv]
// Short command queue between front end and emitter, flip-flop storage.
// Depends on sed_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sed_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  sed_pkg::t_cmd    i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output sed_pkg::t_cmd    o_cmd,
    input  wire              i_pop
);

    sed_pkg::t_cmd               r_mem [sed_pkg::QDEPTH];
    logic [sed_pkg::QAW-1:0]     r_wp, r_rp;
    logic [sed_pkg::QCW-1:0]     r_cnt;

    assign o_full = (r_cnt == sed_pkg::QCW'(sed_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `SED_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `SED_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/sed_back.sv]
// Emitter: walks the head command and sends one decoded word per cycle while o_out is ready.
// Depends on sed_pkg, sed_ifs and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sed_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  sed_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    sed_out_if.source        o_out
);

    typedef enum logic [2:0] {
        PH_BSL,
        PH_LET,
        PH_ZERO,
        PH_DIG,
        PH_VAL,
        PH_TAIL,
        PH_EMPTY,
        PH_NONE
    } t_phase;

    t_phase                    r_ph;
    logic [sed_pkg::CNTW-1:0]  r_idx;
    logic                      r_ov;
    logic                      r_has, r_err, r_zov, r_last, r_done;
    logic [7:0]                r_byte;

    t_phase                    w_cur, w_nxt;
    logic [2:0]                w_cur_code;
    logic [sed_pkg::CNTW-1:0]  w_cnt;
    logic                      w_in_last, w_cmd_last, w_load;
    logic                      n_has, n_err, n_zov;
    logic [7:0]                n_byte;

    function automatic logic [sed_pkg::CNTW-1:0] ph_count(input sed_pkg::t_cmd c,
                                                          input t_phase p);
        logic [sed_pkg::CNTW-1:0] res;
        res = '0;
        unique case (p)
            PH_BSL:   res = sed_pkg::CNTW'(c.pre_en);
            PH_LET:   res = sed_pkg::CNTW'(c.pre_en && c.kind != sed_pkg::KIND_OCT);
            PH_ZERO:  res = sed_pkg::CNTW'(c.nzero);
            PH_DIG:   res = sed_pkg::CNTW'(c.ndig);
            PH_VAL:   res = sed_pkg::CNTW'(c.nval);
            PH_TAIL:  res = sed_pkg::CNTW'(c.tail_en);
            PH_EMPTY: res = sed_pkg::CNTW'(c.empty_res);
            default:  res = '0;
        endcase
        return res;
    endfunction

    function automatic t_phase first_from(input sed_pkg::t_cmd c, input logic [2:0] start);
        t_phase res;
        res = PH_NONE;
        for (int i = int'(PH_EMPTY); i >= 0; i--) begin
            if (3'(i) >= start && ph_count(c, t_phase'(3'(i))) != '0) begin
                res = t_phase'(3'(i));
            end
        end
        return res;
    endfunction

    assign w_cur = first_from(i_cmd, r_ph);
    assign w_cur_code = w_cur;
    assign w_cnt = ph_count(i_cmd, w_cur);
    assign w_nxt = first_from(i_cmd, w_cur_code + 3'd1);
    assign w_in_last = (r_idx + 1'b1 >= w_cnt);
    assign w_cmd_last = w_in_last && (w_nxt == PH_NONE);
    assign w_load = i_valid && (!r_ov || o_out.ready);
    assign o_pop = w_load && w_cmd_last;

    always_comb begin
        n_has = 1'b1;
        n_byte = '0;
        n_err = 1'b0;
        n_zov = i_cmd.zov;
        unique case (w_cur)
            PH_BSL: begin
                n_byte = sed_pkg::CH_BSL;
                n_err = i_cmd.pre_err;
            end
            PH_LET:  n_byte = (i_cmd.kind == sed_pkg::KIND_X) ? sed_pkg::CH_X : sed_pkg::CH_U;
            PH_ZERO: n_byte = sed_pkg::CH_ZERO;
            PH_DIG:  n_byte = i_cmd.dig[r_idx[1:0]];
            PH_VAL:  n_byte = r_idx[0] ? i_cmd.val[15:8] : i_cmd.val[7:0];
            PH_TAIL: begin
                n_byte = i_cmd.tail;
                n_zov = i_cmd.tail_zov;
            end
            PH_EMPTY, PH_NONE: begin
                n_has = 1'b0;
                n_zov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ph <= PH_BSL;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
                r_has <= n_has;
                r_byte <= n_byte;
                r_err <= n_err;
                r_zov <= n_zov;
                r_last <= w_cmd_last;
                r_done <= w_cmd_last && i_cmd.eos;
                if (w_in_last) begin
                    r_idx <= '0;
                    r_ph <= w_cmd_last ? PH_BSL : w_nxt;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.has_byte = r_has;
    assign o_out.out_byte = r_byte;
    assign o_out.escape_error = r_err;
    assign o_out.zero_overflow = r_zov;
    assign o_out.run_last = r_last;
    assign o_out.string_done = r_done;

    `SED_ASSERT(a_phase_found, i_clk, i_rst_n, i_valid |-> (w_cur != PH_NONE), "queued command with no words")
    `SED_ASSERT(a_err_on_bsl, i_clk, i_rst_n, (r_ov && r_err) |-> (r_has && r_byte == sed_pkg::CH_BSL), "error mark not on backslash")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of string_escape_decoder_unit: directed and random string bodies.
// Depends on sed_pkg, sed_ifs and the RTL; predicts every output word and checks it in order.

module tb;
    import sed_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_BSL,
        SCAN_DIGITS,
        SCAN_PREFIX
    } t_scan;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       escape_error;
        logic       zero_overflow;
        logic       run_last;
        logic       string_done;
    } t_word;

    localparam logic [7:0] SIMPLE_LETTERS [11] = '{
        8'h61, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, 8'h76, 8'h3f, 8'h22, 8'h27, 8'h5c
    };

    logic clk = 1'b0;
    logic rst_n;

    sed_in_if  in_ch ();
    sed_out_if out_ch ();

    string_escape_decoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decoder state as predicted
    t_scan       dec_mode;
    t_kind       dec_kind;
    logic [5:0]  dec_zeros;
    logic [7:0]  dec_digits [4];
    logic [2:0]  dec_ndig;
    logic [15:0] dec_value;

    t_word decoded_words [$];
    t_word step_words [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold = 0;
    int items_sent = 0;
    int words_checked = 0;
    int err_words = 0;
    int zov_words = 0;
    int strings_done = 0;
    int mismatches = 0;

    function automatic int hex_digit(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic int simple_code(logic [7:0] c);
        case (c)
            8'h61: return 7;
            8'h62: return 8;
            8'h66: return 12;
            8'h6e: return 10;
            8'h72: return 13;
            8'h74: return 9;
            8'h76: return 11;
            8'h3f, 8'h22, 8'h27, 8'h5c: return int'(c);
            default: return -1;
        endcase
    endfunction

    function automatic void put_byte(logic [7:0] b, bit err, bit zov);
        t_word w;
        w = '{1'b1, b, err, zov, 1'b0, 1'b0};
        step_words.push_back(w);
    endfunction

    function automatic void clear_escape();
        dec_mode = SCAN_IDLE;
        dec_kind = KIND_OCT;
        dec_zeros = '0;
        dec_ndig = '0;
        dec_value = '0;
    endfunction

    function automatic bit zero_excess();
        return dec_zeros > ZERO_MAX;
    endfunction

    function automatic void emit_prefix(bit err, bit zov);
        put_byte(CH_BSL, err, zov);
        if (dec_kind == KIND_X) put_byte(CH_X, 1'b0, zov);
        else if (dec_kind == KIND_U) put_byte(CH_U, 1'b0, zov);
    endfunction

    function automatic void echo_reject(logic [7:0] c);
        bit zov;
        int nz;
        zov = zero_excess();
        nz = zov ? ZERO_MAX : int'(dec_zeros);
        emit_prefix(1'b1, zov);
        for (int i = 0; i < nz; i++) put_byte(CH_ZERO, 1'b0, zov);
        for (int i = 0; i < int'(dec_ndig) && i < 4; i++) put_byte(dec_digits[i], 1'b0, zov);
        put_byte(c, 1'b0, zov);
        clear_escape();
    endfunction

    function automatic void emit_value();
        bit zov;
        zov = zero_excess();
        put_byte(dec_value[7:0], 1'b0, zov);
        if (dec_kind == KIND_U) put_byte(dec_value[15:8], 1'b0, zov);
        clear_escape();
    endfunction

    function automatic void start_plain(logic [7:0] c);
        if (c == CH_BSL) dec_mode = SCAN_BSL;
        else put_byte(c, 1'b0, 1'b0);
    endfunction

    function automatic void take_digit(logic [7:0] c, int d);
        int nxt;
        bit reject;
        if (dec_ndig == 0 && d == 0) begin
            if (dec_zeros <= ZERO_MAX) dec_zeros++;
            return;
        end
        if (dec_kind == KIND_OCT) begin
            nxt = int'(dec_value) * 8 + d;
            reject = nxt > 255;
        end else begin
            nxt = (int'(dec_value) * 16 + d) & 16'hffff;
            reject = dec_ndig >= ((dec_kind == KIND_X) ? 3'd2 : 3'd4);
        end
        if (reject) begin
            echo_reject(c);
            return;
        end
        dec_digits[dec_ndig[1:0]] = c;
        dec_ndig++;
        dec_value = 16'(nxt);
    endfunction

    function automatic void after_backslash(logic [7:0] c);
        int code;
        if (c >= 8'h30 && c <= 8'h37) begin
            dec_kind = KIND_OCT;
            dec_mode = SCAN_DIGITS;
            take_digit(c, int'(c - 8'h30));
            return;
        end
        if (c == CH_X || c == CH_U) begin
            dec_kind = (c == CH_X) ? KIND_X : KIND_U;
            dec_mode = SCAN_PREFIX;
            return;
        end
        code = simple_code(c);
        if (code >= 0) begin
            put_byte(8'(code), 1'b0, 1'b0);
        end else begin
            put_byte(CH_BSL, 1'b1, 1'b0);
            put_byte(c, 1'b0, 1'b0);
        end
        clear_escape();
    endfunction

    function automatic void predict_step(bit hc, logic [7:0] c, bit eos);
        int d;
        t_word w;
        step_words.delete();
        if (hc) begin
            case (dec_mode)
                SCAN_BSL: after_backslash(c);
                SCAN_PREFIX: begin
                    d = hex_digit(c);
                    if (d >= 0) begin
                        dec_mode = SCAN_DIGITS;
                        take_digit(c, d);
                    end else begin
                        emit_prefix(1'b0, 1'b0);
                        clear_escape();
                        start_plain(c);
                    end
                end
                SCAN_DIGITS: begin
                    if (dec_kind == KIND_OCT)
                        d = (c >= 8'h30 && c <= 8'h37) ? int'(c - 8'h30) : -1;
                    else
                        d = hex_digit(c);
                    if (d >= 0) begin
                        take_digit(c, d);
                    end else begin
                        emit_value();
                        start_plain(c);
                    end
                end
                default: begin
                    clear_escape();
                    start_plain(c);
                end
            endcase
        end
        if (eos) begin
            if (dec_mode == SCAN_BSL) put_byte(CH_BSL, 1'b0, 1'b0);
            else if (dec_mode == SCAN_PREFIX) emit_prefix(1'b0, 1'b0);
            else if (dec_mode == SCAN_DIGITS) emit_value();
            clear_escape();
            if (step_words.size() == 0) begin
                w = '0;
                step_words.push_back(w);
            end
            step_words[step_words.size() - 1].string_done = 1'b1;
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1'b1;
        foreach (step_words[i]) decoded_words.push_back(step_words[i]);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 20) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_word(t_word got);
        t_word want;
        if (decoded_words.size() == 0) begin
            report_mismatch($sformatf("word with no prediction, byte %02h", got.out_byte));
            return;
        end
        want = decoded_words.pop_front();
        words_checked++;
        if (got.escape_error) err_words++;
        if (got.zero_overflow) zov_words++;
        if (got.string_done) strings_done++;
        if (got.has_byte !== want.has_byte)
            report_mismatch($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.escape_error !== want.escape_error)
            report_mismatch($sformatf("escape_error %b, want %b",
                                      got.escape_error, want.escape_error));
        if (got.zero_overflow !== want.zero_overflow)
            report_mismatch($sformatf("zero_overflow %b, want %b",
                                      got.zero_overflow, want.zero_overflow));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        if (got.string_done !== want.string_done)
            report_mismatch($sformatf("string_done %b, want %b",
                                      got.string_done, want.string_done));
    endtask

    always @(posedge clk) begin : monitor
        t_word got;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                predict_step(in_ch.has_char, in_ch.char_byte, in_ch.end_of_string);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.has_byte, out_ch.out_byte, out_ch.escape_error,
                        out_ch.zero_overflow, out_ch.run_last, out_ch.string_done};
                check_word(got);
            end
        end
    end

    initial begin : receiver
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (recv_hold > 0) begin
                out_ch.ready <= 1'b0;
                recv_hold--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_word(bit hc, logic [7:0] cb, bit eos);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.has_char <= hc;
        in_ch.char_byte <= cb;
        in_ch.end_of_string <= eos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (hc || eos) items_sent++;
    endtask

    task automatic send_text(string s, bit eos_last);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b1, s[i], eos_last && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (decoded_words.size() != 0) @(posedge clk);
    endtask

    function automatic int zero_run();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    task automatic send_random_string(int ntok);
        int pick;
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
                3: begin
                    send_word(1'b1, CH_BSL, 1'b0);
                    send_word(1'b1, SIMPLE_LETTERS[$urandom_range(0, 10)], 1'b0);
                end
                4: begin
                    send_word(1'b1, CH_BSL, 1'b0);
                    send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
                end
                5: begin
                    send_word(1'b1, CH_BSL, 1'b0);
                    repeat (zero_run()) send_word(1'b1, CH_ZERO, 1'b0);
                    repeat ($urandom_range(1, 4))
                        send_word(1'b1, 8'(8'h30 + $urandom_range(0, 7)), 1'b0);
                end
                6, 7: begin
                    send_word(1'b1, CH_BSL, 1'b0);
                    send_word(1'b1, (pick == 6) ? CH_X : CH_U, 1'b0);
                    repeat (zero_run()) send_word(1'b1, CH_ZERO, 1'b0);
                    repeat ($urandom_range(0, 5)) send_word(1'b1, hex_char(), 1'b0);
                end
                8: send_word($urandom_range(0, 1), 8'($urandom_range(0, 255)),
                             $urandom_range(0, 7) == 0);
                default: send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        send_word($urandom_range(0, 1), 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_phase(int send_pct, int stall_pct, int n_items);
        int stop_at;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) send_random_string($urandom_range(1, 8));
    endtask

    task automatic test_plain_bytes();
        send_word(1'b1, 8'h00, 1'b0);
        send_word(1'b1, 8'hff, 1'b0);
        send_word(1'b0, 8'ha5, 1'b0);
        send_word(1'b0, 8'h5a, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_text("\\n\\q", 1'b1);
    endtask

    task automatic test_octal_escapes();
        send_text("\\377\\400", 1'b1);
    endtask

    task automatic test_hex_escapes();
        send_text("\\xg\\uFfFf\\u12345\\x", 1'b1);
    endtask

    task automatic test_lone_backslash();
        send_text("\\", 1'b1);
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 90);
        run_phase(60, 0, 90);
        run_phase(0, 60, 90);
        run_phase(25, 25, 90);
    endtask

    // hold the output while the longest escapes queue up behind it
    task automatic test_output_backlog();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 300;
        send_text("\\u", 1'b0);
        repeat (ZERO_MAX + 4) send_word(1'b1, CH_ZERO, 1'b0);
        send_text("12345", 1'b0);
        send_word(1'b1, CH_BSL, 1'b0);
        repeat (ZERO_MAX + 8) send_word(1'b1, CH_ZERO, 1'b0);
        send_text("400", 1'b1);
        send_text("abcdef", 1'b0);
        send_random_string(6);
        wait_drained();
    endtask

    initial begin : stimulus
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.has_char <= 1'b0;
        in_ch.char_byte <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        clear_escape();
        foreach (dec_digits[i]) dec_digits[i] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_plain_bytes();
        test_simple_escapes();
        test_octal_escapes();
        test_hex_escapes();
        test_lone_backslash();
        wait_drained();
        test_random_traffic();
        test_output_backlog();
        wait_drained();
        recv_stall_pct = 0;
        repeat (64) @(posedge clk);
        if (decoded_words.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived",
                                      decoded_words.size()));
        $display("covered %0d input words and %0d output words across %0d strings",
                 items_sent, words_checked, strings_done);
        $display("rejected escapes seen: %0d, zero-run overflow words seen: %0d",
                 err_words, zov_words);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sed_pkg.sv
rtl/sed_ifs.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/string_escape_decoder_unit.sv
tb/sv/tb.sv
